// ----- rtl/core/stks_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stks_pkg: shared types and constants of the sorted key search unit
// Operation codes, field widths and the stored entry layout.
// ----------------------------------------------------------------------------
package stks_pkg;

    localparam int DEPTH_DEF = 512;
    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 9;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_table_key_search_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_key_search_unit: sorted key table with binary search
// Keeps up to DEPTH signed keys in sorted order, each with its load tag.
//
// Input channel (i_in_valid / o_in_stall) carries op and key; output channel
// (o_out_valid / i_out_stall) returns one word per input word.
// Clear resets the entry count. Insert shifts every stored key greater than
// the new key up one slot, the memory moving one entry per cycle. Query runs
// a binary search, each probe a read (S_QRD) then a compare (S_QCMP) on the
// shared comparator.
// One word is in work at a time; o_in_stall is high while it runs. A result
// waiting in the output register does not block the next input word, but a
// second result waits until the first is taken.
// Reset empties the table and drops any pending result; memory contents are
// not cleared, only data from positions below the entry count is ever used.
// ----------------------------------------------------------------------------
module sorted_table_key_search_unit #(
    parameter int DEPTH = stks_pkg::DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [stks_pkg::OP_W-1:0]    i_op,
    input  wire logic signed [stks_pkg::KEY_W-1:0] i_key,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_found,
    output logic [stks_pkg::TAG_W-1:0]        o_load_index,
    output logic [stks_pkg::TAG_W-1:0]        o_sorted_position,
    output logic                              o_table_full
);
    import stks_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_QRD,
        S_QCMP,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_pos;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hx;
    logic [CW-1:0]           r_mid;
    logic signed [KEY_W-1:0] r_key;
    logic [TAG_W-1:0]        r_tag;
    logic                    r_res_found;
    logic [TAG_W-1:0]        r_res_li;
    logic [TAG_W-1:0]        r_res_sp;
    logic                    r_res_full;
    logic                    r_ovalid;
    logic                    r_found;
    logic [TAG_W-1:0]        r_li;
    logic [TAG_W-1:0]        r_sp;
    logic                    r_full;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    t_entry                  mem_wdata;
    logic [AW-1:0]           mem_raddr;
    t_entry                  mem_rdata;

    logic                    in_acc;
    logic                    key_gt;
    logic                    key_lt;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic [CW-1:0]           pos_m2;
    logic [CW-1:0]           cnt_m1;
    logic                    out_free;

    stks_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign key_gt   = mem_rdata.key > r_key;
    assign key_lt   = mem_rdata.key < r_key;
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hx} - {{CW{1'b0}}, 1'b1};
    assign mid      = mid_sum[CW:1];
    assign pos_m2   = r_pos - CW'(2);
    assign cnt_m1   = r_count - CW'(1);
    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = '{key: r_key, tag: r_tag};
        mem_raddr = cnt_m1[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = cnt_m1[AW-1:0];
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_raddr = pos_m2[AW-1:0];
                if ((r_pos != '0) && key_gt) begin
                    mem_wdata = mem_rdata;
                end
            end
            S_QRD: begin
                mem_raddr = mid[AW-1:0];
            end
            S_QCMP, S_DONE: begin
                mem_raddr = r_mid[AW-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_key       <= i_key;
                        r_tag       <= TAG_W'(r_count);
                        r_pos       <= r_count;
                        r_lo        <= '0;
                        r_hx        <= r_count;
                        r_res_found <= 1'b0;
                        r_res_li    <= '0;
                        r_res_sp    <= '0;
                        case (i_op)
                            OP_CLEAR: begin
                                r_count    <= '0;
                                r_res_full <= 1'b0;
                                r_state    <= S_DONE;
                            end
                            OP_INSERT: begin
                                if (r_count >= CW'(DEPTH)) begin
                                    r_res_full <= 1'b1;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_res_full <= 1'b0;
                                    r_state    <= S_SHIFT;
                                end
                            end
                            OP_QUERY: begin
                                r_res_full <= 1'b0;
                                r_state    <= S_QRD;
                            end
                            default: begin
                                r_res_full <= 1'b0;
                                r_state    <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    if ((r_pos != '0) && key_gt) begin
                        r_pos <= r_pos - CW'(1);
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_QRD: begin
                    if (r_lo < r_hx) begin
                        r_mid   <= mid;
                        r_state <= S_QCMP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_QCMP: begin
                    if (key_lt) begin
                        r_lo    <= r_mid + CW'(1);
                        r_state <= S_QRD;
                    end else if (key_gt) begin
                        r_hx    <= r_mid;
                        r_state <= S_QRD;
                    end else begin
                        r_res_found <= 1'b1;
                        r_res_li    <= mem_rdata.tag;
                        r_res_sp    <= TAG_W'(r_mid);
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_found  <= r_res_found;
                        r_li     <= r_res_li;
                        r_sp     <= r_res_sp;
                        r_full   <= r_res_full;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_found           = r_found;
    assign o_load_index      = r_li;
    assign o_sorted_position = r_sp;
    assign o_table_full      = r_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ({1'b0, mem_waddr} <= {1'b0, r_count}) && (r_count < CW'(DEPTH)))
        else $error("table write outside the filled region");

    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QCMP) |-> (r_lo <= r_mid) && (r_mid < r_hx) && (r_hx <= r_count))
        else $error("search probe outside its window");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_table_full))
        else $error("hit and full flag together");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && !((r_pos != '0) && key_gt)) |=>
            (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

endmodule
`default_nettype wire

// ----- rtl/core/stks_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stks_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stks_mem #(
    parameter int DEPTH = stks_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire stks_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output stks_pkg::t_entry     o_rdata
);
    import stks_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- tb/sv/sorted_table_key_search_unit_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_key_search_unit_tb: self-checking bench for the sorted key table
// Drives clear, insert, query and unused-op words with random sender bursts
// and receiver stalls. A local sorted-table predictor works out the result words,
// but directed rows may carry their own expected result; each returned word is
// compared field by field in arrival order.
module sorted_table_key_search_unit_tb;
    import stks_pkg::*;

    localparam int TBL_DEPTH    = DEPTH_DEF;
    localparam int ITEMS_TARGET = 1170;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int DIR_N        = 22;

    localparam logic [OP_W-1:0]         OP_NONE = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             found;
        logic [TAG_W-1:0] load_index;
        logic [TAG_W-1:0] sorted_position;
        logic             table_full;
    } t_lookup_res;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic                    typed;
        t_lookup_res             res;
    } t_stim_row;

    localparam t_lookup_res NO_RES   = '0;
    localparam t_lookup_res HIT_HEAD = '{1'b1, 9'd0, 9'd0, 1'b0};

    localparam t_stim_row DIR_ROWS [DIR_N] = '{
        '{OP_QUERY,  32'sd0,          1'b1, NO_RES},
        '{OP_INSERT, KEY_MAX,         1'b1, NO_RES},
        '{OP_INSERT, KEY_MIN,         1'b1, NO_RES},
        '{OP_INSERT, 32'sd0,          1'b1, NO_RES},
        '{OP_INSERT, -32'sd1,         1'b1, NO_RES},
        '{OP_INSERT, 32'sd5,          1'b1, NO_RES},
        '{OP_INSERT, 32'sd5,          1'b1, NO_RES},
        '{OP_INSERT, 32'sd5,          1'b1, NO_RES},
        '{OP_QUERY,  KEY_MIN,         1'b0, NO_RES},
        '{OP_QUERY,  KEY_MAX,         1'b0, NO_RES},
        '{OP_QUERY,  32'sd5,          1'b0, NO_RES},
        '{OP_QUERY,  -32'sd1,         1'b0, NO_RES},
        '{OP_QUERY,  32'sd0,          1'b0, NO_RES},
        '{OP_QUERY,  32'sd4,          1'b1, NO_RES},
        '{OP_QUERY,  32'sh7FFF_FFFE,  1'b1, NO_RES},
        '{OP_NONE,   32'sh5555_AAAA,  1'b1, NO_RES},
        '{OP_QUERY,  32'sd5,          1'b0, NO_RES},
        '{OP_CLEAR,  -32'sd1,         1'b1, NO_RES},
        '{OP_QUERY,  32'sd5,          1'b1, NO_RES},
        '{OP_INSERT, 32'shAAAA_5555,  1'b1, NO_RES},
        '{OP_QUERY,  32'shAAAA_5555,  1'b1, HIT_HEAD},
        '{OP_CLEAR,  32'sd0,          1'b1, NO_RES}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_op = OP_CLEAR;
    logic signed [KEY_W-1:0] i_key = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_found;
    logic [TAG_W-1:0]        o_load_index;
    logic [TAG_W-1:0]        o_sorted_position;
    logic                    o_table_full;

    logic signed [KEY_W-1:0] key_tbl [TBL_DEPTH];
    logic [TAG_W-1:0]        tag_tbl [TBL_DEPTH];
    int                      n_keys = 0;

    t_lookup_res pending_results [$];
    t_lookup_res due_res;

    int err_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int full_seen = 0;
    int cnt_clear = 0;
    int cnt_insert = 0;
    int cnt_query = 0;
    int cnt_none = 0;
    int burst_left = 1;

    logic [7:0] stall_tick = '0;
    logic [1:0] stall_mode = '0;

    sorted_table_key_search_unit #(
        .DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_key            (i_key),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_load_index     (o_load_index),
        .o_sorted_position(o_sorted_position),
        .o_table_full     (o_table_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lookup_res table_step(input logic [OP_W-1:0] op,
                                               input logic signed [KEY_W-1:0] key);
        t_lookup_res r;
        int pos;
        int lo;
        int hi;
        int mid;
        r = '0;
        case (op)
            OP_CLEAR: n_keys = 0;
            OP_INSERT: begin
                if (n_keys >= TBL_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    pos = n_keys;
                    while (pos > 0 && key_tbl[pos-1] > key) begin
                        key_tbl[pos] = key_tbl[pos-1];
                        tag_tbl[pos] = tag_tbl[pos-1];
                        pos--;
                    end
                    key_tbl[pos] = key;
                    tag_tbl[pos] = TAG_W'(n_keys);
                    n_keys++;
                end
            end
            OP_QUERY: begin
                lo = 0;
                hi = n_keys - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (key_tbl[mid] < key) begin
                        lo = mid + 1;
                    end else if (key_tbl[mid] > key) begin
                        hi = mid - 1;
                    end else begin
                        r.found           = 1'b1;
                        r.load_index      = tag_tbl[mid];
                        r.sorted_position = TAG_W'(mid);
                        lo                = hi + 1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 16)) - 32'sd8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] probe_key();
        logic signed [KEY_W-1:0] k;
        if (n_keys > 0 && $urandom_range(0, 9) < 7) begin
            k = key_tbl[$urandom_range(0, n_keys - 1)];
            case ($urandom_range(0, 7))
                0: k = k + 1;
                1: k = k - 1;
                default: ;
            endcase
            return k;
        end
        return rand_key();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        err_count++;
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                             input logic typed = 1'b0, input t_lookup_res typed_res = '0);
        t_lookup_res want;
        int gap;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = table_step(op, key);
        pending_results.push_back(typed ? typed_res : want);
        words_sent++;
        case (op)
            OP_CLEAR:  cnt_clear++;
            OP_INSERT: cnt_insert++;
            OP_QUERY:  cnt_query++;
            default:   cnt_none++;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick == 8'd0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_tick[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                due_res = pending_results.pop_front();
                if (o_found !== due_res.found)
                    report_mismatch("found", o_found, due_res.found);
                if (o_load_index !== due_res.load_index)
                    report_mismatch("load_index", o_load_index, due_res.load_index);
                if (o_sorted_position !== due_res.sorted_position)
                    report_mismatch("sorted_position", o_sorted_position,
                                    due_res.sorted_position);
                if (o_table_full !== due_res.table_full)
                    report_mismatch("table_full", o_table_full, due_res.table_full);
                if (due_res.found) hits_seen++;
                if (due_res.table_full) full_seen++;
            end
            results_seen++;
        end
    end

    initial begin
        int i;
        int n_ins;
        int n_q;
        int wait_cycles;
        logic signed [KEY_W-1:0] k;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_N; i++) begin
            send_word(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end
        drain_results();

        // fill to capacity, largest key last so it lands on the top slot
        send_word(OP_CLEAR, rand_key());
        for (i = 0; i < TBL_DEPTH - 1; i++) begin
            k = rand_key();
            if (k == KEY_MAX) k = k - 1;
            send_word(OP_INSERT, k);
        end
        send_word(OP_INSERT, KEY_MAX);
        send_word(OP_INSERT, KEY_MIN);
        send_word(OP_INSERT, rand_key());
        send_word(OP_INSERT, KEY_MAX);
        send_word(OP_QUERY, KEY_MAX);
        send_word(OP_QUERY, KEY_MIN);
        for (i = 0; i < 20; i++) send_word(OP_QUERY, probe_key());
        drain_results();

        while (words_sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 19) < 16 || n_keys > 400) begin
                send_word(OP_CLEAR, rand_key());
                n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                    : $urandom_range(0, 12);
            end else begin
                n_ins = $urandom_range(0, 6);
            end
            for (i = 0; i < n_ins; i++) send_word(OP_INSERT, rand_key());
            n_q = $urandom_range(3, 14);
            for (i = 0; i < n_q; i++) begin
                case ($urandom_range(0, 15))
                    0: send_word(OP_NONE, $urandom);
                    1: send_word(OP_INSERT, rand_key());
                    default: send_word(OP_QUERY, probe_key());
                endcase
            end
            if ($urandom_range(0, 11) == 0) drain_results();
        end

        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TBL_DEPTH + 16) @(posedge i_clk);

        $display("run covered %0d words: %0d clears, %0d inserts, %0d queries, %0d unused-op",
                 words_sent, cnt_clear, cnt_insert, cnt_query, cnt_none);
        $display("%0d results checked, %0d query hits, %0d full-table refusals, %0d mismatches",
                 results_seen, hits_seen, full_seen, err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("sorted_table_key_search_unit_tb: PASS");
        end else begin
            $display("sorted_table_key_search_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("timeout: %0d results still pending", pending_results.size());
        $display("sorted_table_key_search_unit_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sorted_table_key_search_unit.f -----
rtl/core/stks_pkg.sv
rtl/core/stks_mem.sv
rtl/core/sorted_table_key_search_unit.sv
tb/sv/sorted_table_key_search_unit_tb.sv
